>>> design/rbse_pkg.sv
// Shared widths, reset values, codes and types of the robust base/spread estimator.
// No dependencies; every other design file depends on this package.
`timescale 1ns / 1ps
package rbse_pkg;

  localparam int WARMUP_LEN   = 50;
  localparam int CNT_W        = 6;
  localparam int OBS_W        = 24;
  localparam int WGT_W        = 17;
  localparam int COEF_W       = 20;
  localparam int RATE_W       = 20;
  localparam int HUB_W        = 19;
  localparam int BASE_W       = 21;
  localparam int SPR_W        = 19;
  localparam int CEN_W        = 24;
  localparam int GRAD_W       = 24;
  localparam int ERR_W        = 20;
  localparam int ES_W         = 24;
  localparam int MA_W         = 25;
  localparam int MB_W         = 21;
  localparam int MP_W         = MA_W + MB_W;
  localparam int PB_W         = 38;
  localparam int PS_W         = 42;
  localparam int SB_W         = 40;
  localparam int DIV_W        = 44;
  localparam int TOT_W        = 19;
  localparam int DCNT_W       = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;
  localparam int UP_W         = RATE_W + 1 + GRAD_W;

  localparam logic signed [BASE_W-1:0] BASE_RESET = BASE_W'(-294912);
  localparam logic signed [BASE_W-1:0] BASE_MIN   = BASE_W'(-589824);
  localparam logic signed [BASE_W-1:0] BASE_MAX   = BASE_W'(131072);
  localparam logic [SPR_W-1:0]         SPR_RESET  = SPR_W'(65536);
  localparam logic [SPR_W-1:0]         SPR_MAX    = SPR_W'(262144);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_CALM     = 3'd0,
    REG_COEF_TREND    = 3'd1,
    REG_COEF_CRISIS   = 3'd2,
    REG_RATE_BASE     = 3'd3,
    REG_RATE_SPR_UP   = 3'd4,
    REG_RATE_SPR_DOWN = 3'd5,
    REG_HUBER_SCALE   = 3'd6,
    REG_MIN_SPREAD    = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_CEN,
    LOP_ES,
    LOP_WB,
    LOP_WS
  } lane_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CEN,
    S_ES,
    S_WB,
    S_WS,
    S_DGO,
    S_DIV,
    S_GRAD,
    S_UPB,
    S_UPS,
    S_REC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic signed [CEN_W-1:0] center;
    logic signed [PB_W-1:0]  wt_err;
    logic signed [PS_W-1:0]  wt_err_coef;
  } lane_res_t;

endpackage

>>> design/rbse_if.sv
// Handshake channels of the estimator: input ticks, results and register writes.
// Depends on rbse_pkg for the field widths.
`timescale 1ns / 1ps
interface rbse_tick_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rbse_pkg::OBS_W-1:0]    observation;
  logic                                 sample_valid;
  logic [rbse_pkg::WGT_W-1:0]           weight_calm;
  logic [rbse_pkg::WGT_W-1:0]           weight_trend;
  logic [rbse_pkg::WGT_W-1:0]           weight_crisis;
  modport source (output valid, observation, sample_valid, weight_calm, weight_trend,
                  weight_crisis, input ready);
  modport sink (input valid, observation, sample_valid, weight_calm, weight_trend,
                weight_crisis, output ready);
endinterface

interface rbse_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rbse_pkg::CEN_W-1:0]    center_calm;
  logic signed [rbse_pkg::CEN_W-1:0]    center_trend;
  logic signed [rbse_pkg::CEN_W-1:0]    center_crisis;
  logic signed [rbse_pkg::BASE_W-1:0]   base_out;
  logic [rbse_pkg::SPR_W-1:0]           spread_out;
  logic                                 updated;
  logic signed [rbse_pkg::GRAD_W-1:0]   gradient_base;
  logic signed [rbse_pkg::GRAD_W-1:0]   gradient_spread;
  modport source (output valid, center_calm, center_trend, center_crisis, base_out,
                  spread_out, updated, gradient_base, gradient_spread, input ready);
  modport sink (input valid, center_calm, center_trend, center_crisis, base_out,
                spread_out, updated, gradient_base, gradient_spread, output ready);
endinterface

interface rbse_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [rbse_pkg::CFG_IDX_W-1:0]       index;
  logic [rbse_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/rbse_lane.sv
// One regime lane: center, clipped error and weighted products through one multiplier.
// Depends on rbse_pkg.
`timescale 1ns / 1ps
module rbse_lane (
  input  logic                                clk,
  input  rbse_pkg::lane_op_t                  op,
  input  logic signed [rbse_pkg::COEF_W-1:0]  coef,
  input  logic signed [rbse_pkg::BASE_W-1:0]  base,
  input  logic [rbse_pkg::SPR_W-1:0]          spread,
  input  logic signed [rbse_pkg::OBS_W-1:0]   obs,
  input  logic [rbse_pkg::WGT_W-1:0]          wgt,
  input  logic [rbse_pkg::HUB_W-1:0]          huber,
  output rbse_pkg::lane_res_t                 res
);
  import rbse_pkg::*;

  logic signed [CEN_W-1:0] center;
  logic signed [ERR_W-1:0] errc;
  logic signed [ES_W-1:0]  es;
  logic signed [PB_W-1:0]  pb;
  logic signed [PS_W-1:0]  ps;

  logic signed [MA_W-1:0]  err_full;
  logic signed [MA_W-1:0]  hub_s;
  logic signed [ERR_W-1:0] errc_comb;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [MP_W-1:0]  prod;

  always_comb begin
    err_full = {obs[OBS_W-1], obs} - {center[CEN_W-1], center};
    hub_s    = {{(MA_W-HUB_W){1'b0}}, huber};
    if (err_full > hub_s) begin
      errc_comb = hub_s[ERR_W-1:0];
    end else if (err_full < -hub_s) begin
      errc_comb = ERR_W'(-hub_s);
    end else begin
      errc_comb = err_full[ERR_W-1:0];
    end
    case (op)
      LOP_CEN: begin
        ma = {{(MA_W-COEF_W){coef[COEF_W-1]}}, coef};
        mb = {{(MB_W-SPR_W){1'b0}}, spread};
      end
      LOP_ES: begin
        ma = {{(MA_W-ERR_W){errc_comb[ERR_W-1]}}, errc_comb};
        mb = {{(MB_W-COEF_W){coef[COEF_W-1]}}, coef};
      end
      LOP_WB: begin
        ma = {{(MA_W-ERR_W){errc[ERR_W-1]}}, errc};
        mb = {{(MB_W-WGT_W){1'b0}}, wgt};
      end
      LOP_WS: begin
        ma = {{(MA_W-ES_W){es[ES_W-1]}}, es};
        mb = {{(MB_W-WGT_W){1'b0}}, wgt};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;
  end

  // The arithmetic shift of the product by 16 is a floor, as the fixed-point scaling needs.
  always_ff @(posedge clk) begin
    case (op)
      LOP_CEN: center <= {{(CEN_W-BASE_W){base[BASE_W-1]}}, base} + prod[39:16];
      LOP_ES: begin
        errc <= errc_comb;
        es   <= prod[39:16];
      end
      LOP_WB:  pb <= prod[PB_W-1:0];
      LOP_WS:  ps <= prod[PS_W-1:0];
      default: ;
    endcase
  end

  assign res.center      = center;
  assign res.wt_err      = pb;
  assign res.wt_err_coef = ps;

endmodule

>>> design/rbse_div.sv
// Restoring divider, one quotient bit per cycle, for the gradient normalization.
// Depends on rbse_pkg.
`timescale 1ns / 1ps
module rbse_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rbse_pkg::DIV_W-1:0]    dividend,
  input  logic [rbse_pkg::TOT_W-1:0]    divisor,
  output logic [rbse_pkg::DIV_W-1:0]    quotient,
  output logic                          busy
);
  import rbse_pkg::*;

  logic [TOT_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic [TOT_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(DIV_W);
      quo  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? TOT_W'(trial - {1'b0, divisor}) : trial[TOT_W-1:0];
      quo  <= {quo[DIV_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule

>>> design/robust_base_spread_estimator_unit.sv
// Top level of the robust base/spread estimator: three regime lanes, merge, dividers, update.
// Depends on rbse_pkg, rbse_if, rbse_lane and rbse_div.
// Ticks are taken one at a time; a stalled result holds the input. A tick that does
// not update goes from the lane centers to the output step; one that does passes the
// clipped error, weighted products, bit-serial division, gradient, updates and new centers.
// Reset (synchronous, active high) restores register defaults, levels and the warmup count.
`timescale 1ns / 1ps
module robust_base_spread_estimator_unit (
  input  logic     clk,
  input  logic     rst,
  rbse_tick_if.sink     tick,
  rbse_result_if.source result,
  rbse_cfg_if.sink      cfg
);
  import rbse_pkg::*;

  // Configuration registers.
  logic signed [COEF_W-1:0] coef [3];
  logic [RATE_W-1:0]        rate_base;
  logic [RATE_W-1:0]        rate_spr_up;
  logic [RATE_W-1:0]        rate_spr_down;
  logic [HUB_W-1:0]         huber_scale;
  logic [SPR_W-1:0]         spread_floor;

  // Estimator state.
  logic signed [BASE_W-1:0] base_est;
  logic [SPR_W-1:0]         spread_level;
  logic [CNT_W-1:0]         tick_cnt;
  logic signed [GRAD_W-1:0] held_grad_base;
  logic signed [GRAD_W-1:0] held_grad_spread;

  // Item held while it is worked on.
  logic signed [OBS_W-1:0]  obs;
  logic [WGT_W-1:0]         wgt [3];
  logic                     upd;
  logic [TOT_W-1:0]         tot;
  logic                     neg_b;
  logic                     neg_s;

  state_t    state;
  state_t    state_next;
  lane_op_t  lane_op;
  logic      div_start;
  lane_res_t lres [3];

  logic                     div_busy_b;
  logic                     div_busy_s;
  logic [DIV_W-1:0]         quo_b;
  logic [DIV_W-1:0]         quo_s;
  logic signed [SB_W-1:0]   sum_b;
  logic signed [DIV_W-1:0]  sum_s;
  logic [DIV_W-1:0]         mag_b;
  logic [DIV_W-1:0]         mag_s;
  logic [CNT_W-1:0]         cnt_next;

  logic signed [RATE_W:0]   up_rate;
  logic signed [GRAD_W-1:0] up_grad;
  logic signed [UP_W-1:0]   up_prod;
  logic signed [BASE_W+3:0] base_sum;
  logic signed [BASE_W+3:0] spr_sum;
  logic signed [BASE_W+3:0] min_ext;

  logic                     tick_acc;
  logic                     out_load;

  assign tick.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign tick_acc   = tick.valid && tick.ready;
  assign cnt_next   = (tick_cnt < CNT_W'(WARMUP_LEN)) ? tick_cnt + 1'b1 : tick_cnt;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rbse_lane u_lane (
      .clk    (clk),
      .op     (lane_op),
      .coef   (coef[k]),
      .base   (base_est),
      .spread (spread_level),
      .obs    (obs),
      .wgt    (wgt[k]),
      .huber  (huber_scale),
      .res    (lres[k])
    );
  end

  // Merge of the lane products; a zero weight contributes nothing to any sum.
  always_comb begin
    sum_b = SB_W'(lres[0].wt_err) + SB_W'(lres[1].wt_err) + SB_W'(lres[2].wt_err);
    sum_s = DIV_W'(lres[0].wt_err_coef) + DIV_W'(lres[1].wt_err_coef)
          + DIV_W'(lres[2].wt_err_coef);
    mag_b = DIV_W'(sum_b[SB_W-1] ? -sum_b : sum_b);
    mag_s = sum_s[DIV_W-1] ? DIV_W'(-sum_s) : sum_s;
  end

  rbse_div u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_b),
    .divisor  (tot),
    .quotient (quo_b),
    .busy     (div_busy_b)
  );

  rbse_div u_div_s (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_s),
    .divisor  (tot),
    .quotient (quo_s),
    .busy     (div_busy_s)
  );

  // Level update: one multiplier, base in one cycle and spread in the next.
  always_comb begin
    if (state == S_UPS) begin
      up_rate = {1'b0, (held_grad_spread > 0) ? rate_spr_up : rate_spr_down};
      up_grad = held_grad_spread;
    end else begin
      up_rate = {1'b0, rate_base};
      up_grad = held_grad_base;
    end
    up_prod  = up_rate * up_grad;
    base_sum = {{4{base_est[BASE_W-1]}}, base_est}
             + {up_prod[43], up_prod[43:20]};
    spr_sum  = {6'b0, spread_level} + {up_prod[43], up_prod[43:20]};
    min_ext  = {6'b0, spread_floor};
  end

  always_comb begin
    state_next = state;
    lane_op    = LOP_IDLE;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: if (tick_acc) state_next = S_CEN;
      S_CEN: begin
        lane_op    = LOP_CEN;
        state_next = upd ? S_ES : S_OUT;
      end
      S_ES: begin
        lane_op    = LOP_ES;
        state_next = S_WB;
      end
      S_WB: begin
        lane_op    = LOP_WB;
        state_next = S_WS;
      end
      S_WS: begin
        lane_op    = LOP_WS;
        state_next = S_DGO;
      end
      S_DGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV:  if (!div_busy_b && !div_busy_s) state_next = S_GRAD;
      S_GRAD: state_next = S_UPB;
      S_UPB:  state_next = S_UPS;
      S_UPS:  state_next = S_REC;
      S_REC: begin
        lane_op    = LOP_CEN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]       <= COEF_W'(-65536);
      coef[1]       <= '0;
      coef[2]       <= COEF_W'(98304);
      rate_base     <= RATE_W'(10486);
      rate_spr_up   <= RATE_W'(52429);
      rate_spr_down <= RATE_W'(1049);
      huber_scale   <= HUB_W'(65536);
      spread_floor  <= SPR_W'(32768);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        REG_COEF_CALM:     coef[0]       <= cfg.data[COEF_W-1:0];
        REG_COEF_TREND:    coef[1]       <= cfg.data[COEF_W-1:0];
        REG_COEF_CRISIS:   coef[2]       <= cfg.data[COEF_W-1:0];
        REG_RATE_BASE:     rate_base     <= cfg.data[RATE_W-1:0];
        REG_RATE_SPR_UP:   rate_spr_up   <= cfg.data[RATE_W-1:0];
        REG_RATE_SPR_DOWN: rate_spr_down <= cfg.data[RATE_W-1:0];
        REG_HUBER_SCALE:   huber_scale   <= cfg.data[HUB_W-1:0];
        REG_MIN_SPREAD:    spread_floor  <= cfg.data[SPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_est         <= BASE_RESET;
      spread_level     <= SPR_RESET;
      tick_cnt         <= '0;
      held_grad_base   <= '0;
      held_grad_spread <= '0;
      upd              <= 1'b0;
      result.valid     <= 1'b0;
    end else begin
      if (tick_acc) begin
        obs      <= tick.observation;
        wgt[0]   <= tick.weight_calm;
        wgt[1]   <= tick.weight_trend;
        wgt[2]   <= tick.weight_crisis;
        tot      <= TOT_W'(tick.weight_calm) + TOT_W'(tick.weight_trend)
                  + TOT_W'(tick.weight_crisis);
        tick_cnt <= cnt_next;
        upd      <= (cnt_next >= CNT_W'(WARMUP_LEN)) && tick.sample_valid;
      end
      if (state == S_DGO) begin
        neg_b <= sum_b[SB_W-1];
        neg_s <= sum_s[DIV_W-1];
      end
      // Quotients round toward zero: divide magnitudes, then restore the sign.
      if (state == S_GRAD) begin
        if (tot == '0) begin
          held_grad_base   <= '0;
          held_grad_spread <= '0;
        end else begin
          held_grad_base   <= neg_b ? GRAD_W'(-quo_b) : quo_b[GRAD_W-1:0];
          held_grad_spread <= neg_s ? GRAD_W'(-quo_s) : quo_s[GRAD_W-1:0];
        end
      end
      if (state == S_UPB) begin
        if (base_sum < $signed({{4{BASE_MIN[BASE_W-1]}}, BASE_MIN})) begin
          base_est <= BASE_MIN;
        end else if (base_sum > $signed({{4{BASE_MAX[BASE_W-1]}}, BASE_MAX})) begin
          base_est <= BASE_MAX;
        end else begin
          base_est <= base_sum[BASE_W-1:0];
        end
      end
      // Low clamp first, then high clamp, so a minimum above four still ends at four.
      if (state == S_UPS) begin
        if (spr_sum < min_ext) begin
          spread_level <= (spread_floor > SPR_MAX) ? SPR_MAX : spread_floor;
        end else if (spr_sum > {6'b0, SPR_MAX}) begin
          spread_level <= SPR_MAX;
        end else begin
          spread_level <= spr_sum[SPR_W-1:0];
        end
      end
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.center_calm     <= lres[0].center;
      result.center_trend    <= lres[1].center;
      result.center_crisis   <= lres[2].center;
      result.base_out        <= base_est;
      result.spread_out      <= spread_level;
      result.updated         <= upd;
      result.gradient_base   <= held_grad_base;
      result.gradient_spread <= held_grad_spread;
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    tick_cnt <= CNT_W'(WARMUP_LEN))
    else $error("warmup count past its limit");

  a_spread_rng: assert property (@(posedge clk) disable iff (rst)
    spread_level <= SPR_MAX)
    else $error("spread above its upper clamp");

  a_base_rng: assert property (@(posedge clk) disable iff (rst)
    base_est >= BASE_MIN && base_est <= BASE_MAX)
    else $error("base outside its clamp range");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> state == S_CEN)
    else $error("accepted tick did not start the lanes");

  a_out_from_fsm: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_OUT)
    else $error("result beat raised outside the output step");

endmodule

>>> tb/sv/rbse_tb_if.sv
// Testbench-side note: the channel interfaces come from the design file rbse_if.sv.
// This file holds the shared result type of the bench; depends on rbse_pkg.
`timescale 1ns / 1ps
package rbse_tb_pkg;
  import rbse_pkg::*;

  // One result beat as the bench predicts and compares it.
  typedef struct {
    logic signed [CEN_W-1:0]  center_calm;
    logic signed [CEN_W-1:0]  center_trend;
    logic signed [CEN_W-1:0]  center_crisis;
    logic signed [BASE_W-1:0] base_out;
    logic [SPR_W-1:0]         spread_out;
    logic                     updated;
    logic signed [GRAD_W-1:0] gradient_base;
    logic signed [GRAD_W-1:0] gradient_spread;
  } estimate_t;
endpackage

>>> tb/sv/rbse_checker.sv
// Watches the tick, result and register channels, predicts each result and compares.
// Depends on rbse_pkg, rbse_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps
module rbse_checker (
  input  logic          clk,
  input  logic          rst,
  rbse_tick_if.sink     tick,
  rbse_result_if.sink   result,
  rbse_cfg_if.sink      cfg,
  output int            fail_count,
  output int            pending
);
  import rbse_pkg::*;
  import rbse_tb_pkg::*;

  longint coef_q[3];
  longint rate_b, rate_up, rate_dn, huber, min_spr;
  longint base_lvl, spread_lvl, held_gb, held_gs;
  int     ticks_seen;
  estimate_t estimate_q[$];

  function automatic longint floor_shr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint center_of(int k);
    return base_lvl + floor_shr(coef_q[k] * spread_lvl, 16);
  endfunction

  task automatic reset_model();
    coef_q[0] = -65536; coef_q[1] = 0; coef_q[2] = 98304;
    rate_b = 10486; rate_up = 52429; rate_dn = 1049;
    huber = 65536; min_spr = 32768;
    base_lvl = -294912; spread_lvl = 65536;
    ticks_seen = 0; held_gb = 0; held_gs = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (cfg_idx_t'(idx))
      REG_COEF_CALM:     coef_q[0] = longint'($signed(d));
      REG_COEF_TREND:    coef_q[1] = longint'($signed(d));
      REG_COEF_CRISIS:   coef_q[2] = longint'($signed(d));
      REG_RATE_BASE:     rate_b = d;
      REG_RATE_SPR_UP:   rate_up = d;
      REG_RATE_SPR_DOWN: rate_dn = d;
      REG_HUBER_SCALE:   huber = d[HUB_W-1:0];
      REG_MIN_SPREAD:    min_spr = d[HUB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_tick(longint obs, logic ok, longint w[3]);
    estimate_t e;
    longint sb, ss, tot, gb, gs, err, r;
    bit upd;
    upd = 0;
    if (ticks_seen < WARMUP_LEN) ticks_seen++;
    if (ticks_seen >= WARMUP_LEN && ok) begin
      upd = 1; sb = 0; ss = 0; tot = 0; gb = 0; gs = 0;
      for (int k = 0; k < 3; k++) begin
        if (w[k] != 0) begin
          err = obs - center_of(k);
          if (err > huber) err = huber;
          if (err < -huber) err = -huber;
          sb += w[k] * err;
          ss += w[k] * floor_shr(err * coef_q[k], 16);
          tot += w[k];
        end
      end
      // SystemVerilog integer division truncates toward zero, as required.
      if (tot > 0) begin
        gb = sb / tot;
        gs = ss / tot;
      end
      held_gb = gb; held_gs = gs;
      base_lvl += floor_shr(rate_b * gb, 20);
      r = (gs > 0) ? rate_up : rate_dn;
      spread_lvl += floor_shr(r * gs, 20);
      if (spread_lvl < min_spr) spread_lvl = min_spr;
      if (spread_lvl > 262144) spread_lvl = 262144;
      if (base_lvl < -589824) base_lvl = -589824;
      if (base_lvl > 131072) base_lvl = 131072;
    end
    e.center_calm = center_of(0);
    e.center_trend = center_of(1);
    e.center_crisis = center_of(2);
    e.base_out = base_lvl;
    e.spread_out = spread_lvl;
    e.updated = upd;
    e.gradient_base = held_gb;
    e.gradient_spread = held_gs;
    estimate_q.push_back(e);
  endtask

  task automatic compare_field(string nm, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, nm, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    estimate_t e;
    longint w[3];
    if (rst) begin
      reset_model();
      estimate_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
      if (result.valid && result.ready) begin
        if (estimate_q.size() == 0) begin
          $display("%0t unexpected result beat", $time);
          fail_count++;
        end else begin
          e = estimate_q.pop_front();
          compare_field("center_calm", e.center_calm, result.center_calm);
          compare_field("center_trend", e.center_trend, result.center_trend);
          compare_field("center_crisis", e.center_crisis, result.center_crisis);
          compare_field("base_out", e.base_out, result.base_out);
          compare_field("spread_out", e.spread_out, result.spread_out);
          compare_field("updated", e.updated, result.updated);
          compare_field("gradient_base", e.gradient_base, result.gradient_base);
          compare_field("gradient_spread", e.gradient_spread, result.gradient_spread);
        end
      end
      if (tick.valid && tick.ready) begin
        w[0] = tick.weight_calm; w[1] = tick.weight_trend; w[2] = tick.weight_crisis;
        predict_tick(longint'(tick.observation), tick.sample_valid, w);
      end
    end
    pending = estimate_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the estimator bench: clock, reset, stimulus, register phases and verdict.
// Depends on rbse_pkg, the channel interfaces, rbse_checker and the design top.
`timescale 1ns / 1ps
module tb_top;
  import rbse_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left;
  bit   hold_req = 1'b0;
  bit   hold_taken;
  bit   done = 1'b0;

  rbse_tick_if   tick();
  rbse_result_if result();
  rbse_cfg_if    cfg();

  robust_base_spread_estimator_unit u_dut (.clk(clk), .rst(rst), .tick(tick),
                                           .result(result), .cfg(cfg));
  rbse_checker u_chk (.clk(clk), .rst(rst), .tick(tick), .result(result), .cfg(cfg),
                      .fail_count(fail_count), .pending(pending));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      result.ready <= 1'b0;
      hold_left    <= 300;
      hold_taken   <= 1'b1;
    end else if (hold_left > 0) begin
      result.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_tick(logic signed [OBS_W-1:0] obs, int ok, int wc, int wt, int wk);
    while ($urandom_range(99) < send_idle_pct) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid <= 1'b1; tick.observation <= obs; tick.sample_valid <= (ok != 0);
    tick.weight_calm <= WGT_W'(wc); tick.weight_trend <= WGT_W'(wt);
    tick.weight_crisis <= WGT_W'(wk);
    do @(posedge clk); while (!tick.ready);
    tick.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every prediction has been matched, then lets the block settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return WGT_W'(65536);
      2: return WGT_W'($urandom_range(131071));
      default: return WGT_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic signed [OBS_W-1:0] rand_obs();
    case ($urandom_range(5))
      0: return OBS_W'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      default: return OBS_W'($signed($urandom_range(655360)) - 524288);
    endcase
  endfunction

  task automatic random_ticks(int n);
    for (int i = 0; i < n; i++)
      send_tick(rand_obs(), $urandom_range(9) != 0, rand_weight(), rand_weight(),
                rand_weight());
  endtask

  task automatic random_config(bit extreme);
    cfg_idx_t idx;
    for (int r = 0; r < 8; r++) begin
      idx = cfg_idx_t'(r);
      if (r <= 2)
        write_cfg(idx, extreme ? ($urandom_range(1) ? 20'h7FFFF : 20'h80000)
                               : 20'($signed($urandom_range(262144)) - 131072));
      else if (r <= 5)
        write_cfg(idx, extreme ? ($urandom_range(1) ? 20'hFFFFF : 20'h0)
                               : 20'($urandom_range(1048575)));
      else
        write_cfg(idx, extreme ? ($urandom_range(1) ? 20'd262144 : 20'd0)
                               : 20'($urandom_range(262144)));
    end
  endtask

  initial begin
    tick.valid = 1'b0; tick.observation = '0; tick.sample_valid = 1'b0;
    tick.weight_calm = '0; tick.weight_trend = '0; tick.weight_crisis = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Warmup: valid and invalid ticks up to and past the count's saturation, then edges.
    for (int i = 0; i < 52; i++)
      send_tick(i[0] ? -24'sh4_8000 : 24'sh0, i % 3 != 0, 65536, 0, 0);
    send_tick(24'sh7FFFFF, 1, 65536, 65536, 65536);
    send_tick(-24'sh800000, 1, 131071, 131071, 131071);
    send_tick(24'sh0, 1, 0, 0, 0);
    send_tick(24'sh12345, 0, 100, 200, 300);
    send_tick(-24'sh30000, 1, 1, 0, 0);
    send_tick(24'sh1_0000, 1, 0, 1, 65536);
    drain();

    // Min spread at four, and a coefficient change visible at once.
    write_cfg(REG_MIN_SPREAD, 20'd262144);
    write_cfg(REG_COEF_TREND, 20'h7FFFF);
    send_tick(24'sh0, 1, 65536, 65536, 0);
    send_tick(24'sh0, 0, 0, 0, 0);
    drain();
    write_cfg(REG_MIN_SPREAD, 20'd0);
    write_cfg(REG_HUBER_SCALE, 20'd0);
    send_tick(24'sh50000, 1, 65536, 65536, 65536);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      random_config(ph == 3 || ph == 6);
      if (ph == 4) hold_req = 1'b1;
      random_ticks(190);
      drain();
    end
    done = 1'b1;
  end

  initial begin
    wait (done);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
